/* src/smwf_pkg.sv */
// Shared types and constants of the streaming multilevel wavelet filter bank.
package smwf_pkg;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECIMATE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVELS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TAPS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SELECT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LP_COEF = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HP_COEF = 3'd7;
  localparam int COEF_W = 18;
  localparam int WORD_W = 32;

  typedef struct packed {
    logic [2:0]  level_index;
    logic        band;
    logic [31:0] coefficient;
    logic        last;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

/* src/smwf_if.sv */
// Valid/ready stream interfaces for the input samples and result items.
interface smwf_in_if #(parameter int W = 16) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface smwf_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  level_index;
  logic        band;
  logic [31:0] coefficient;
  logic        last;
  modport source (output valid, output level_index, output band, output coefficient,
                  output last, input ready);
  modport sink (input valid, input level_index, input band, input coefficient,
                input last, output ready);
endinterface

/* src/smwf_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module smwf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule

/* src/smwf_front.sv */
// Front end: accepts a raw sample, scales it by the gain, adds the offset and saturates it into a Q15.16 word.
module smwf_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_raw,
  input  logic signed [31:0]     gain,
  input  logic signed [31:0]     offset,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [31:0]            q_word
);
  logic                 prod_v_r;
  logic signed [64:0]   prod_r;
  logic                 word_v_r;
  logic [31:0]          word_r;
  logic signed [65:0]   sum;

  assign in_ready = !prod_v_r && !word_v_r;
  assign sum = 66'(prod_r) + 66'(offset);
  assign q_valid = word_v_r;
  assign q_word = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      word_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        prod_v_r <= 1'b1;
        prod_r <= $signed({1'b0, in_raw}) * gain;
      end else if (prod_v_r && !word_v_r) begin
        prod_v_r <= 1'b0;
        word_v_r <= 1'b1;
        word_r <= smwf_pkg::sat32(sum);
      end else if (word_v_r && q_ready) begin
        word_v_r <= 1'b0;
      end
    end
  end
endmodule

/* src/smwf_back.sv */
// Back end: runs the level cascade with one shared lowpass/highpass MAC pair.
module smwf_back #(
  parameter int MAX_TAPS = 16,
  parameter int MAX_LEVELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [31:0]         q_word,
  input  logic                decimate,
  input  logic [3:0]          level_cfg,
  input  logic [4:0]          tap_cfg,
  input  logic                coef_we_lp,
  input  logic                coef_we_hp,
  input  logic [3:0]          coef_sel,
  input  logic [17:0]         coef_data,
  output logic                res_valid,
  input  logic                res_ready,
  output smwf_pkg::result_t   res
);
  localparam int HIST = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SLW = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int FW = $clog2(HIST + 1);
  localparam int HD = MAX_LEVELS * (2 ** SLW);
  localparam int HAW = $clog2(HD);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MAC, S_ADD, S_EMIT, S_APPROX, S_WAIT
  } state_t;

  state_t state_r;
  logic [LIW-1:0] lev_r;
  logic [TW-1:0]  t_r;
  logic [TW-1:0]  taps_r;
  logic [LW-1:0]  levels_r;
  logic [31:0]    x_r;
  logic signed [65:0] al_r, ah_r;
  logic signed [49:0] pl_r, ph_r;
  logic           pv_r;
  logic [31:0]    lp_r, hp_r;
  logic [MAX_LEVELS-1:0] phase_r;
  logic [SLW-1:0] wp_r [MAX_LEVELS];
  logic [FW-1:0]  fill_r [MAX_LEVELS];
  logic           fire_r;
  logic           rv_r;
  smwf_pkg::result_t res_r;

  logic [17:0] lp_tab_r [MAX_TAPS];
  logic [17:0] hp_tab_r [MAX_TAPS];

  logic            hwe;
  logic [HAW-1:0]  hwaddr, hraddr;
  logic [31:0]     hwdata, hrdata;
  logic [TW-1:0]   age;
  logic [SLW-1:0]  rslot;
  logic [31:0]     samp;
  logic            sel_ok;
  logic [TW-1:0]   taps_c;
  logic [LW-1:0]   levels_c;
  logic            next_skip;

  smwf_ram #(.WIDTH(32), .DEPTH(HD)) u_hist (
    .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
    .raddr(hraddr), .rdata(hrdata)
  );

  assign taps_c = (tap_cfg == 5'd0) ? TW'(1) :
                  (32'(tap_cfg) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_cfg);
  assign levels_c = (level_cfg == 4'd0) ? LW'(1) :
                    (32'(level_cfg) > MAX_LEVELS) ? LW'(MAX_LEVELS) : LW'(level_cfg);
  assign sel_ok = 32'(coef_sel) < MAX_TAPS;

  // Each level keeps its past inputs in a ring; entries not yet written read as zero.
  assign age = taps_r - TW'(1) - t_r;
  assign rslot = wp_r[lev_r] - SLW'(age);
  assign hraddr = HAW'({lev_r, rslot});
  assign samp = (age == '0) ? x_r :
                ((32'(age) <= 32'(fill_r[lev_r])) ? hrdata : 32'd0);

  assign hwe = (state_r == S_EMIT) && !rv_r;
  assign hwaddr = HAW'({lev_r, wp_r[lev_r]});
  assign hwdata = x_r;

  // The next level skips when its phase bit is set, so this detail ends the item.
  assign next_skip = (LW'(lev_r) + LW'(1) != levels_r) && decimate &&
                     phase_r[lev_r + LIW'(1)];

  assign q_ready = (state_r == S_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (coef_we_lp && sel_ok) lp_tab_r[CIW'(coef_sel)] <= coef_data;
    if (coef_we_hp && sel_ok) hp_tab_r[CIW'(coef_sel)] <= coef_data;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        lp_tab_r[i] <= '0;
        hp_tab_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      rv_r <= 1'b0;
      pv_r <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        wp_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (rv_r && res_ready) rv_r <= 1'b0;
      if (hwe) begin
        wp_r[lev_r] <= wp_r[lev_r] + SLW'(1);
        if (32'(fill_r[lev_r]) < HIST) fill_r[lev_r] <= fill_r[lev_r] + FW'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && !rv_r) begin
            x_r <= q_word;
            lev_r <= '0;
            taps_r <= taps_c;
            levels_r <= levels_c;
            t_r <= '0;
            al_r <= '0;
            ah_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MAC;
        end
        S_MAC: begin
          pl_r <= $signed(samp) * $signed(lp_tab_r[CIW'(t_r)]);
          ph_r <= $signed(samp) * $signed(hp_tab_r[CIW'(t_r)]);
          pv_r <= 1'b1;
          if (pv_r) begin
            al_r <= al_r + 66'(pl_r);
            ah_r <= ah_r + 66'(ph_r);
          end
          if (t_r + TW'(1) == taps_r) state_r <= S_ADD;
          else begin
            t_r <= t_r + TW'(1);
            state_r <= S_RD;
          end
        end
        S_ADD: begin
          pv_r <= 1'b0;
          lp_r <= smwf_pkg::sat32(66'((al_r + 66'(pl_r) + 66'sd32768) >>> 16));
          hp_r <= smwf_pkg::sat32(66'((ah_r + 66'(ph_r) + 66'sd32768) >>> 16));
          fire_r <= !decimate || !phase_r[lev_r];
          if (decimate) phase_r[lev_r] <= !phase_r[lev_r];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!rv_r) begin
            if (!fire_r) begin
              state_r <= S_WAIT;
            end else begin
              rv_r <= 1'b1;
              res_r.level_index <= 3'(lev_r);
              res_r.band <= 1'b0;
              res_r.coefficient <= hp_r;
              res_r.last <= next_skip;
              if (LW'(lev_r) + LW'(1) == levels_r) begin
                state_r <= S_APPROX;
              end else begin
                lev_r <= lev_r + LIW'(1);
                x_r <= lp_r;
                t_r <= '0;
                al_r <= '0;
                ah_r <= '0;
                state_r <= S_RD;
              end
            end
          end
        end
        S_APPROX: begin
          if (!rv_r) begin
            rv_r <= 1'b1;
            res_r.level_index <= 3'(lev_r);
            res_r.band <= 1'b1;
            res_r.coefficient <= lp_r;
            res_r.last <= 1'b1;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/streaming_multilevel_wavelet_filterbank_core.sv */
// Top level of the streaming multilevel wavelet filter bank.
// One sample is in the cascade at a time: the back end takes no new sample until it has
// finished with the last, and every tap waits in S_RD for the registered history read
// before its multiply-accumulate in S_MAC; a stalled result output also holds the back end.
module streaming_multilevel_wavelet_filterbank_core #(
  parameter int MAX_TAPS = 16,
  parameter int MAX_LEVELS = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  smwf_in_if.sink                            in_ch,
  smwf_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [smwf_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [smwf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  logic signed [31:0] gain_r, offset_r;
  logic decim_r;
  logic [3:0] levels_r, sel_r;
  logic [4:0] taps_r;
  logic q_valid, q_ready;
  logic [31:0] q_word;
  smwf_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 32'sd65536;
      offset_r <= '0;
      decim_r <= 1'b1;
      levels_r <= 4'd1;
      taps_r <= 5'd2;
      sel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smwf_pkg::REG_GAIN:     gain_r <= cfg_data;
        smwf_pkg::REG_OFFSET:   offset_r <= cfg_data;
        smwf_pkg::REG_DECIMATE: decim_r <= cfg_data[0];
        smwf_pkg::REG_LEVELS:   levels_r <= cfg_data[3:0];
        smwf_pkg::REG_TAPS:     taps_r <= cfg_data[4:0];
        smwf_pkg::REG_SELECT:   sel_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  smwf_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_raw(in_ch.raw_sample), .gain(gain_r), .offset(offset_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  smwf_back #(.MAX_TAPS(MAX_TAPS), .MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .decimate(decim_r), .level_cfg(levels_r), .tap_cfg(taps_r),
    .coef_we_lp(cfg_we && cfg_index == smwf_pkg::REG_LP_COEF),
    .coef_we_hp(cfg_we && cfg_index == smwf_pkg::REG_HP_COEF),
    .coef_sel(sel_r), .coef_data(cfg_data[17:0]),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.level_index = res.level_index;
  assign out_ch.band = res.band;
  assign out_ch.coefficient = res.coefficient;
  assign out_ch.last = res.last;
endmodule

/* src/smwf_checker.sv */
// Port-level checker for the wavelet filter bank, bound to the top level.
module smwf_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_band,
  input logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result item dropped");
  a_approx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_band |-> out_last) else $error("approximation not last");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind streaming_multilevel_wavelet_filterbank_core smwf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_band(out_ch.band), .out_last(out_ch.last)
);

/* tb/sv/tb_streaming_multilevel_wavelet_filterbank_core.sv */
// Testbench for the streaming multilevel wavelet filter bank: predicts results and checks them.
class wavelet_scoreboard;
  logic signed [31:0] gain;
  logic signed [31:0] offset;
  logic decimate;
  logic [3:0] levels;
  logic [4:0] taps;
  logic [3:0] select;
  logic signed [31:0] history[8][15];
  logic signed [17:0] lp_coef[16];
  logic signed [17:0] hp_coef[16];
  logic [7:0] phase;
  smwf_pkg::result_t pending[$];
  int errors;

  function new();
    gain = 32'sd65536;
    offset = 0;
    decimate = 1;
    levels = 1;
    taps = 2;
    select = 0;
    phase = 0;
    errors = 0;
    foreach (history[i, j]) history[i][j] = 0;
    foreach (lp_coef[i]) begin
      lp_coef[i] = 0;
      hp_coef[i] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      smwf_pkg::REG_GAIN: gain = value;
      smwf_pkg::REG_OFFSET: offset = value;
      smwf_pkg::REG_DECIMATE: decimate = value[0];
      smwf_pkg::REG_LEVELS: levels = value[3:0];
      smwf_pkg::REG_TAPS: taps = value[4:0];
      smwf_pkg::REG_SELECT: select = value[3:0];
      smwf_pkg::REG_LP_COEF: lp_coef[select] = value[17:0];
      smwf_pkg::REG_HP_COEF: hp_coef[select] = value[17:0];
      default: ;
    endcase
  endfunction

  function logic signed [31:0] clamp(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [31:0] round_acc(logic signed [65:0] acc);
    logic signed [65:0] q;
    q = (acc + 66'sd32768) >>> 16;
    return clamp(q);
  endfunction

  function void note_sample(logic [15:0] raw);
    int nlev;
    int ntap;
    int age;
    bit fire;
    bit deepest;
    logic signed [31:0] x;
    logic signed [31:0] lp;
    logic signed [31:0] hp;
    logic signed [65:0] al;
    logic signed [65:0] ah;
    logic signed [65:0] s;
    smwf_pkg::result_t r;
    int first;
    nlev = (levels < 1) ? 1 : (levels > 8) ? 8 : levels;
    ntap = (taps < 1) ? 1 : (taps > 16) ? 16 : taps;
    x = clamp($signed({50'd0, raw}) * $signed({{34{gain[31]}}, gain})
              + $signed({{34{offset[31]}}, offset}));
    deepest = 0;
    lp = 0;
    first = pending.size();
    for (int lev = 0; lev < nlev; lev++) begin
      fire = 1;
      if (decimate) begin
        fire = !phase[lev];
        phase[lev] = !phase[lev];
      end
      al = 0;
      ah = 0;
      for (int t = 0; t < ntap; t++) begin
        age = ntap - 1 - t;
        s = (age == 0) ? x : history[lev][age-1];
        al += s * lp_coef[t];
        ah += s * hp_coef[t];
      end
      for (int k = 14; k > 0; k--) history[lev][k] = history[lev][k-1];
      history[lev][0] = x;
      lp = round_acc(al);
      hp = round_acc(ah);
      if (!fire) break;
      r.level_index = 3'(lev);
      r.band = 0;
      r.coefficient = hp;
      r.last = 0;
      pending.push_back(r);
      x = lp;
      if (lev + 1 == nlev) deepest = 1;
    end
    if (deepest) begin
      r.level_index = 3'(nlev - 1);
      r.band = 1;
      r.coefficient = lp;
      r.last = 0;
      pending.push_back(r);
    end
    if (pending.size() > first) pending[pending.size()-1].last = 1;
  endfunction

  function void check_result(smwf_pkg::result_t got);
    smwf_pkg::result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result item %p", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.level_index !== want.level_index) begin
      $error("level_index: expected %0d actual %0d", want.level_index, got.level_index);
      errors++;
    end
    if (got.band !== want.band) begin
      $error("band: expected %0d actual %0d", want.band, got.band);
      errors++;
    end
    if (got.coefficient !== want.coefficient) begin
      $error("coefficient: expected %0d actual %0d", $signed(want.coefficient),
             $signed(got.coefficient));
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d actual %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_streaming_multilevel_wavelet_filterbank_core;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [smwf_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
  logic [smwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  longint cycles = 0;
  bit sending_done = 0;
  wavelet_scoreboard sb;

  smwf_in_if #(16) in_ch (clk);
  smwf_out_if out_ch (clk);

  streaming_multilevel_wavelet_filterbank_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, value);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] raw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.raw_sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(raw);
  endtask

  task automatic load_filter(int ntap, bit rand_coef);
    for (int t = 0; t < 16; t++) begin
      write_reg(smwf_pkg::REG_SELECT, t);
      write_reg(smwf_pkg::REG_LP_COEF,
                rand_coef ? $urandom : ((t < ntap) ? 32'd32768 : 32'd0));
      write_reg(smwf_pkg::REG_HP_COEF, rand_coef ? $urandom
                : ((t < ntap) ? ((t % 2) ? 32'h3c000 : 32'd16384) : 32'd0));
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.raw_sample = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_sample(16'h0000);
    send_sample(16'hffff);
    wait_drained();
    load_filter(2, 0);
    write_reg(smwf_pkg::REG_LEVELS, 8);
    send_sample(16'hffff);
    send_sample(16'h0000);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    send_sample(16'h8000);
    send_sample(16'h0001);
    wait_drained();
    write_reg(smwf_pkg::REG_GAIN, 32'h7fffffff);
    write_reg(smwf_pkg::REG_OFFSET, 32'h7fffffff);
    write_reg(smwf_pkg::REG_TAPS, 16);
    send_sample(16'hffff);
    send_sample(16'hffff);
    wait_drained();
    write_reg(smwf_pkg::REG_GAIN, 32'h80000000);
    write_reg(smwf_pkg::REG_OFFSET, 32'h80000000);
    write_reg(smwf_pkg::REG_DECIMATE, 0);
    write_reg(smwf_pkg::REG_LEVELS, 0);
    write_reg(smwf_pkg::REG_TAPS, 0);
    send_sample(16'hffff);
    send_sample(16'h1234);
    wait_drained();
    write_reg(smwf_pkg::REG_LEVELS, 15);
    write_reg(smwf_pkg::REG_TAPS, 31);
    load_filter(0, 1);
    send_sample(16'hffff);
    send_sample(16'h7fff);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(smwf_pkg::REG_GAIN,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
      write_reg(smwf_pkg::REG_OFFSET,
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535));
      write_reg(smwf_pkg::REG_DECIMATE, ph < 2);
      write_reg(smwf_pkg::REG_LEVELS, (ph == 0) ? 8 : $urandom_range(1, 8));
      write_reg(smwf_pkg::REG_TAPS, (ph == 3) ? 16 : $urandom_range(1, 6));
      load_filter(0, 1);
      for (int n = 0; n < 36; n++) send_sample($urandom);
      wait_drained();
    end
    sending_done = 1;
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && rst_n)
      sb.check_result('{out_ch.level_index, out_ch.band, out_ch.coefficient, out_ch.last});
  end

  initial begin
    int g;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g == 0) out_ch.ready <= 1;
      else begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
        out_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
src/smwf_pkg.sv
src/smwf_if.sv
src/smwf_ram.sv
src/smwf_front.sv
src/smwf_back.sv
src/streaming_multilevel_wavelet_filterbank_core.sv
src/smwf_checker.sv
tb/sv/tb_streaming_multilevel_wavelet_filterbank_core.sv
